@@ hw/rtl/tsrs_pkg.sv @@
// Package for the temperature sensor read sequencer.
// Holds the item types, phase, command and error codes, and the CRC8 step.
// No dependencies.
package tsrs_pkg;

  localparam int unsigned SCRATCH_LEN = 9;
  localparam int unsigned CNT_W       = $clog2(SCRATCH_LEN + 1);
  localparam int unsigned IDX_W       = $clog2(SCRATCH_LEN);

  localparam logic [31:0] DELAY_RESET = 32'd750000;

  // Item functions.
  localparam logic [2:0] FN_POLL  = 3'd0;
  localparam logic [2:0] FN_START = 3'd1;
  localparam logic [2:0] FN_RX    = 3'd2;
  localparam logic [2:0] FN_ACK   = 3'd3;
  localparam logic [2:0] FN_CLEAR = 3'd4;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_RESET   = 3'd1;
  localparam logic [2:0] PH_CONVERT = 3'd2;
  localparam logic [2:0] PH_WAIT    = 3'd3;
  localparam logic [2:0] PH_REQ     = 3'd4;
  localparam logic [2:0] PH_READ    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  // Bus commands.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_RESET = 3'd1;
  localparam logic [2:0] CMD_TX    = 3'd2;
  localparam logic [2:0] CMD_RX    = 3'd3;
  localparam logic [2:0] CMD_CLR   = 3'd4;

  // Bus status on polls.
  localparam logic [1:0] BUS_BUSY  = 2'd0;
  localparam logic [1:0] BUS_DONE  = 2'd1;
  localparam logic [1:0] BUS_ERROR = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_NODEV = 2'd1;
  localparam logic [1:0] ERR_COMM  = 2'd2;
  localparam logic [1:0] ERR_CRC   = 2'd3;

  localparam logic [7:0] BYTE_CONVERT = 8'h44;
  localparam logic [7:0] BYTE_READ    = 8'hBE;
  localparam logic [7:0] CRC_POLY     = 8'h8C;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_us;
    logic [1:0]  bus_status;
    logic        bus_no_device;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         bus_cmd;
    logic [7:0]         tx_byte;
    logic               start_refused;
    logic [2:0]         phase_now;
    logic               busy_flag;
    logic               data_ready;
    logic               has_error;
    logic [1:0]         error_code;
    logic signed [15:0] temperature;
  } out_item_t;

  // One byte of the reflected Maxim CRC8, one bit per step.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/tsrs_if.sv @@
// Handshake channel interfaces for the temperature sensor read sequencer.
// The input channel carries one request item, the output channel one result.
// No dependencies.
interface tsrs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] now_us;
  logic [1:0]  bus_status;
  logic        bus_no_device;
  logic [7:0]  rx_byte;

  modport source (output valid, func, now_us, bus_status, bus_no_device, rx_byte,
                  input ready);
  modport sink   (input valid, func, now_us, bus_status, bus_no_device, rx_byte,
                  output ready);
endinterface

interface tsrs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         bus_cmd;
  logic [7:0]         tx_byte;
  logic               start_refused;
  logic [2:0]         phase_now;
  logic               busy_flag;
  logic               data_ready;
  logic               has_error;
  logic [1:0]         error_code;
  logic signed [15:0] temperature;

  modport source (output valid, bus_cmd, tx_byte, start_refused, phase_now, busy_flag,
                  data_ready, has_error, error_code, temperature,
                  input ready);
  modport sink   (input valid, bus_cmd, tx_byte, start_refused, phase_now, busy_flag,
                  data_ready, has_error, error_code, temperature,
                  output ready);
endinterface

@@ hw/rtl/tsrs_core.sv @@
// Sequencer state and the per-item step logic.
// Updates the state on each stepped item and gives the result combinationally.
// Depends on tsrs_pkg.
module tsrs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tsrs_pkg::in_item_t item_i,
  input  logic [31:0]        delay_i,
  output tsrs_pkg::out_item_t result_o
);
  import tsrs_pkg::*;

  logic [2:0]       phase_q, phase_d;
  logic             after_read_q, after_read_d;
  logic             pending_q, pending_d;
  logic             busy_q, busy_d;
  logic [1:0]       error_q, error_d;
  logic [31:0]      wait_start_q, wait_start_d;
  logic [CNT_W-1:0] rx_count_q, rx_count_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       scratch_q [SCRATCH_LEN];
  logic             scratch_we;
  logic             show_temp;
  logic [31:0]      elapsed;
  logic             room;

  assign elapsed = item_i.now_us - wait_start_q;
  assign room    = rx_count_q < CNT_W'(SCRATCH_LEN);

  always_comb begin
    phase_d      = phase_q;
    after_read_d = after_read_q;
    pending_d    = pending_q;
    busy_d       = busy_q;
    error_d      = error_q;
    wait_start_d = wait_start_q;
    rx_count_d   = rx_count_q;
    crc_d        = crc_q;
    scratch_we   = 1'b0;
    show_temp    = 1'b0;
    result_o     = '0;

    unique case (item_i.func)
      FN_POLL: begin
        unique case (phase_q)
          PH_RESET: begin
            if (!pending_q) begin
              result_o.bus_cmd = CMD_RESET;
              pending_d        = 1'b1;
            end else if (item_i.bus_status == BUS_DONE) begin
              pending_d = 1'b0;
              phase_d   = after_read_q ? PH_REQ : PH_CONVERT;
            end else if (item_i.bus_status == BUS_ERROR) begin
              phase_d = PH_ERROR;
              error_d = item_i.bus_no_device ? ERR_NODEV : ERR_COMM;
            end
          end
          PH_CONVERT: begin
            if (!pending_q) begin
              result_o.bus_cmd = CMD_TX;
              result_o.tx_byte = BYTE_CONVERT;
              pending_d        = 1'b1;
            end else if (item_i.bus_status == BUS_DONE) begin
              pending_d    = 1'b0;
              phase_d      = PH_WAIT;
              wait_start_d = item_i.now_us;
            end else if (item_i.bus_status == BUS_ERROR) begin
              phase_d = PH_ERROR;
              error_d = ERR_COMM;
            end
          end
          PH_WAIT: begin
            // The difference wraps, so a timestamp roll-over is harmless.
            if (elapsed >= delay_i) begin
              phase_d      = PH_RESET;
              after_read_d = 1'b1;
            end
          end
          PH_REQ: begin
            if (!pending_q) begin
              result_o.bus_cmd = CMD_TX;
              result_o.tx_byte = BYTE_READ;
              pending_d        = 1'b1;
            end else if (item_i.bus_status == BUS_DONE) begin
              pending_d = 1'b0;
              phase_d   = PH_READ;
            end else if (item_i.bus_status == BUS_ERROR) begin
              phase_d = PH_ERROR;
              error_d = ERR_COMM;
            end
          end
          PH_READ: begin
            if (!pending_q) begin
              result_o.bus_cmd = CMD_RX;
              pending_d        = 1'b1;
              rx_count_d       = '0;
              crc_d            = '0;
            end else if (item_i.bus_status == BUS_DONE) begin
              if (room) begin
                phase_d = PH_ERROR;
                error_d = ERR_COMM;
              end else if (crc_q == scratch_q[SCRATCH_LEN-1]) begin
                pending_d = 1'b0;
                phase_d   = PH_DONE;
              end else begin
                phase_d = PH_ERROR;
                error_d = ERR_CRC;
              end
            end else if (item_i.bus_status == BUS_ERROR) begin
              phase_d = PH_ERROR;
              error_d = ERR_COMM;
            end
          end
          PH_ERROR: pending_d = 1'b0;
          default: ;
        endcase
      end
      FN_START: begin
        if (busy_q) begin
          result_o.start_refused = 1'b1;
        end else begin
          phase_d      = PH_RESET;
          after_read_d = 1'b0;
          busy_d       = 1'b1;
        end
      end
      FN_RX: begin
        if (phase_q == PH_READ && pending_q && room) begin
          scratch_we = 1'b1;
          // The last byte is the check value and stays out of the CRC.
          if (rx_count_q < CNT_W'(SCRATCH_LEN - 1)) begin
            crc_d = crc8_step(crc_q, item_i.rx_byte);
          end
          rx_count_d = rx_count_q + CNT_W'(1);
        end
      end
      FN_ACK: begin
        show_temp = (phase_q == PH_DONE);
        phase_d   = PH_IDLE;
        busy_d    = 1'b0;
      end
      FN_CLEAR: begin
        error_d          = ERR_NONE;
        phase_d          = PH_IDLE;
        busy_d           = 1'b0;
        pending_d        = 1'b0;
        result_o.bus_cmd = CMD_CLR;
      end
      default: ;
    endcase

    if (phase_d == PH_DONE) begin
      show_temp = 1'b1;
    end

    result_o.phase_now   = phase_d;
    result_o.busy_flag   = busy_d;
    result_o.data_ready  = (phase_d == PH_DONE);
    result_o.has_error   = (phase_d == PH_ERROR);
    result_o.error_code  = error_d;
    result_o.temperature = show_temp ? $signed({scratch_q[1], scratch_q[0]}) : 16'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      after_read_q <= 1'b0;
      pending_q    <= 1'b0;
      busy_q       <= 1'b0;
      error_q      <= ERR_NONE;
      wait_start_q <= '0;
      rx_count_q   <= '0;
      crc_q        <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      after_read_q <= after_read_d;
      pending_q    <= pending_d;
      busy_q       <= busy_d;
      error_q      <= error_d;
      wait_start_q <= wait_start_d;
      rx_count_q   <= rx_count_d;
      crc_q        <= crc_d;
    end
  end

  // Scratchpad bytes hold no reset; each is read only after a full receive.
  always_ff @(posedge clk_i) begin
    if (step_i && scratch_we) begin
      scratch_q[rx_count_q[IDX_W-1:0]] <= item_i.rx_byte;
    end
  end

endmodule

@@ hw/rtl/temp_sensor_read_sequencer.sv @@
// Top level of the temperature sensor read sequencer.
// Input register, step core, result register and the delay register.
// Depends on tsrs_pkg, tsrs_in_if, tsrs_out_if and tsrs_core.
//
//   Channel   Direction  Handshake        Contents
//   in_i      sink       valid / ready    func, now_us, bus_status, bus_no_device, rx_byte
//   out_o     source     valid / ready    bus command, phase, flags, error code, temperature
//   cfg       write      cfg_we_i         conversion delay in microseconds
//
// One item per cycle is sustained while out_o is ready; an item is held in the input
// register, and the step logic between the input and result registers places its result
// in the result register, from which it transfers out.
// Reset clears all control state at once; the scratchpad needs no clearing pass.
// While the result is not taken, the input register holds one more item and then
// input ready falls.
module temp_sensor_read_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsrs_in_if.sink     in_i,
  tsrs_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import tsrs_pkg::*;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q;
  out_item_t   result;
  logic [31:0] delay_q;
  logic        step;

  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      delay_q     <= DELAY_RESET;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q.func          <= in_i.func;
      in_item_q.now_us        <= in_i.now_us;
      in_item_q.bus_status    <= in_i.bus_status;
      in_item_q.bus_no_device <= in_i.bus_no_device;
      in_item_q.rx_byte       <= in_i.rx_byte;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  tsrs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .delay_i  (delay_q),
    .result_o (result)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.bus_cmd       = out_item_q.bus_cmd;
  assign out_o.tx_byte       = out_item_q.tx_byte;
  assign out_o.start_refused = out_item_q.start_refused;
  assign out_o.phase_now     = out_item_q.phase_now;
  assign out_o.busy_flag     = out_item_q.busy_flag;
  assign out_o.data_ready    = out_item_q.data_ready;
  assign out_o.has_error     = out_item_q.has_error;
  assign out_o.error_code    = out_item_q.error_code;
  assign out_o.temperature   = out_item_q.temperature;

endmodule
